// ===== src/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } lpfd_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] payload_byte;
        logic [7:0] source_node;
        logic       last;
    } lpfd_out_t;

    typedef enum logic [4:0] {
        PH_LEN   = 5'b00001,
        PH_MAGIC = 5'b00010,
        PH_SRC   = 5'b00100,
        PH_PAY   = 5'b01000,
        PH_DEAD  = 5'b10000
    } phase_t;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_CONN = 1'b1;

    localparam logic [2:0] ST_PAYLOAD   = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_BAD_MSG   = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_ABORTED   = 3'd4;

    localparam logic [31:0] HDR_BYTES = 32'd8;
    localparam logic [1:0]  FIELD_END = 2'd3;

    localparam logic [0:3][7:0] MAGIC = {8'h50, 8'h43, 8'h50, 8'h31};

endpackage

// ===== src/length_prefixed_frame_deframer_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_core
// Splits a length-prefixed byte stream into validated payload transactions.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_data): one stream byte or a
// new-connection marker per transaction. Output channel (out_valid /
// out_stall / out_data): zero or one result per input transaction, carrying
// status, payload byte, source node and last marker.
// own_node is written through cfg_wr_en / cfg_wr_data; the user must write
// it only while the block idles, as the block does not enforce this.
// Throughput: one input transaction per cycle while in_stall is low; the
// parse state update and header checks are combinational between the state
// registers and the output register (or the skid register under a stall).
// A two-entry output stage (output register plus skid register) lets input
// continue while one result waits; in_stall rises only when both entries
// hold results, i.e. after the receiver has stalled with a result pending
// and another result has been produced.
// Reset clears the parse state to expecting a length field, clears own_node
// and empties the output stage.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_core #(
    parameter int MAX_NODE_ID = 255,
    parameter int MAX_PAYLOAD = 65535
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  lpfd_pkg::lpfd_in_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output lpfd_pkg::lpfd_out_t out_data
);
    import lpfd_pkg::*;

    localparam int REM_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [31:0] MAX_LEN = 32'(MAX_PAYLOAD) + HDR_BYTES;
    localparam logic [31:0] MAX_SRC = 32'(MAX_NODE_ID);

    logic [7:0]       own_node_reg;
    phase_t           phase_reg, phase_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [23:0]      len_reg, len_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [23:0]      src_reg, src_next;
    logic             bad_reg, bad_next;

    logic             out_valid_reg, skid_valid_reg;
    lpfd_out_t        out_data_reg, skid_data_reg;

    logic             accept;
    logic             res_valid;
    lpfd_out_t        res;
    logic [31:0]      len_full;
    logic [31:0]      src_full;
    logic             src_bad;
    logic             mid;
    logic             done;
    logic             out_free;

    assign accept   = in_valid && !skid_valid_reg;
    assign len_full = {len_reg, in_data.data_byte};
    assign src_full = {src_reg, in_data.data_byte};
    assign src_bad  = (src_full == 32'd0) || (src_full > MAX_SRC)
                      || (src_full == {24'd0, own_node_reg});
    assign mid      = (phase_reg == PH_MAGIC) || (phase_reg == PH_SRC)
                      || (phase_reg == PH_PAY)
                      || ((phase_reg == PH_LEN) && (cnt_reg != 2'd0));
    assign done     = (rem_reg == REM_W'(1));

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        src_next   = src_reg;
        bad_next   = bad_reg;
        res_valid  = 1'b0;
        res        = '0;
        if (in_data.opcode == OP_CONN)
        begin
            phase_next = PH_LEN;
            cnt_next   = 2'd0;
            len_next   = '0;
            rem_next   = '0;
            src_next   = '0;
            bad_next   = 1'b0;
            res_valid  = mid;
            res.status = ST_ABORTED;
        end
        else
        begin
            case (phase_reg)
                PH_LEN:
                begin
                    len_next = len_full[23:0];
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == FIELD_END)
                    begin
                        if ((len_full < HDR_BYTES) || (len_full > MAX_LEN))
                        begin
                            phase_next = PH_DEAD;
                            res_valid  = 1'b1;
                            res.status = ST_BAD_LEN;
                        end
                        else
                        begin
                            rem_next   = REM_W'(len_full - HDR_BYTES);
                            bad_next   = 1'b0;
                            phase_next = PH_MAGIC;
                        end
                    end
                end
                PH_MAGIC:
                begin
                    if (in_data.data_byte != MAGIC[cnt_reg])
                    begin
                        bad_next = 1'b1;
                    end
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == FIELD_END)
                    begin
                        src_next   = '0;
                        phase_next = PH_SRC;
                    end
                end
                PH_SRC:
                begin
                    src_next = src_full[23:0];
                    cnt_next = cnt_reg + 2'd1;
                    if (cnt_reg == FIELD_END)
                    begin
                        if (rem_reg == '0)
                        begin
                            phase_next = PH_LEN;
                            len_next   = '0;
                            src_next   = '0;
                            bad_next   = 1'b0;
                            res_valid  = 1'b1;
                            if (bad_reg || src_bad)
                            begin
                                res.status = ST_BAD_MSG;
                            end
                            else
                            begin
                                res.status      = ST_EMPTY;
                                res.source_node = src_full[7:0];
                            end
                        end
                        else
                        begin
                            bad_next   = bad_reg || src_bad;
                            phase_next = PH_PAY;
                        end
                    end
                end
                PH_PAY:
                begin
                    rem_next = rem_reg - REM_W'(1);
                    if (done)
                    begin
                        phase_next = PH_LEN;
                        cnt_next   = 2'd0;
                        len_next   = '0;
                        src_next   = '0;
                        bad_next   = 1'b0;
                    end
                    if (!bad_reg)
                    begin
                        res_valid        = 1'b1;
                        res.status       = ST_PAYLOAD;
                        res.payload_byte = in_data.data_byte;
                        res.source_node  = src_reg[7:0];
                        res.last         = done;
                    end
                    else if (done)
                    begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_MSG;
                    end
                end
                PH_DEAD:
                begin
                    phase_next = PH_DEAD;
                end
                default:
                begin
                    phase_next = PH_LEN;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            own_node_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEN;
            cnt_reg   <= '0;
            len_reg   <= '0;
            rem_reg   <= '0;
            src_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
            rem_reg   <= rem_next;
            src_reg   <= src_next;
            bad_reg   <= bad_next;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || (accept && res_valid);
            skid_valid_reg <= 1'b0;
        end
        else if (accept && res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (accept && res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
